>>> rtl/core/midi_track_to_note_words_top_macros.svh
// Assertion macros used by the checker file.
`ifndef MIDI_TRACK_TO_NOTE_WORDS_TOP_MACROS_SVH
`define MIDI_TRACK_TO_NOTE_WORDS_TOP_MACROS_SVH

// Checks that an antecedent implies a consequent on the same clock edge.
`define MTN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent on the next clock edge.
`define MTN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mtnw_pkg.sv
`default_nettype none
package mtnw_pkg;

    localparam int unsigned NOTE_COUNT_DEF = 128;
    localparam int unsigned TIME_LIMIT_DEF = 1998787;
    localparam int unsigned TEMPO_W        = 24;
    localparam int unsigned TIME_W         = 21;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd480000;

    localparam logic [15:0] WORD_START = 16'hA000;
    localparam logic [15:0] WORD_END   = 16'hFFFF;
    localparam logic [15:0] WORD_DELAY = 16'h8000;
    localparam logic [TIME_W-1:0] DELAY_MAX = 21'h7FFF;

    localparam logic [7:0] META_TEMPO = 8'h51;

    typedef enum logic [2:0] {
        KIND_START = 3'd0,
        KIND_DELAY = 3'd1,
        KIND_NOTE  = 3'd2,
        KIND_END   = 3'd3,
        KIND_RANGE = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_HDRSKIP  = 4'd1,
        PH_DELTA    = 4'd2,
        PH_DELTA2   = 4'd3,
        PH_EVENT    = 4'd4,
        PH_METATYPE = 4'd5,
        PH_METALEN  = 4'd6,
        PH_SYSLEN   = 4'd7,
        PH_NOTE     = 4'd8,
        PH_SKIP     = 4'd9
    } phase_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load_in;
        logic       start_file;
        logic       parse;
        logic       mul;
        logic       acc;
        logic       drain;
        logic       note;
        logic       finish;
        logic       out_load;
        logic [1:0] out_sel;
    } cmd_t;

    localparam logic [1:0] OSEL_START = 2'd0;
    localparam logic [1:0] OSEL_DELAY = 2'd1;
    localparam logic [1:0] OSEL_NOTE  = 2'd2;
    localparam logic [1:0] OSEL_END   = 2'd3;

    typedef struct packed {
        logic start_sent;
        logic need_add;
        logic is_note;
        logic time_zero;
        logic is_last;
    } status_t;

    // Note step: integer part of 1445.0688 * 2^((n-72)/12), 0x8000 and above flagged.
    function automatic logic [16:0] note_step(input logic [6:0] n);
        logic [63:0] ratio;
        logic [63:0] v;
        unique case (n % 7'd12)
            7'd0:  ratio = 64'd1000000000;
            7'd1:  ratio = 64'd1059463094;
            7'd2:  ratio = 64'd1122462048;
            7'd3:  ratio = 64'd1189207115;
            7'd4:  ratio = 64'd1259921050;
            7'd5:  ratio = 64'd1334839854;
            7'd6:  ratio = 64'd1414213562;
            7'd7:  ratio = 64'd1498307077;
            7'd8:  ratio = 64'd1587401052;
            7'd9:  ratio = 64'd1681792831;
            7'd10: ratio = 64'd1781797436;
            default: ratio = 64'd1887748625;
        endcase
        v = (64'd225792 * ratio) << (n / 7'd12);
        v = v / 64'd10000000000000;
        note_step = (v >= 64'h8000) ? 17'h10000 : {1'b0, v[15:0]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/mtnw_ctrl.sv
`default_nettype none
module mtnw_ctrl
    import mtnw_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_fire,
    input  wire logic    out_free,
    input  wire status_t stat,
    output logic         in_ready,
    output cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_PARSE = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_ACC   = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_END   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load_in = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (stat.start_sent) begin
                    state_next = S_PARSE;
                end else if (out_free) begin
                    cmd.start_file = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_sel = OSEL_START;
                    state_next = S_PARSE;
                end
            end
            S_PARSE: begin
                if (stat.is_note) begin
                    state_next = S_DRAIN;
                end else begin
                    cmd.parse = 1'b1;
                    state_next = stat.need_add ? S_MUL : S_END;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                state_next = S_END;
            end
            S_DRAIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    if (!stat.time_zero) begin
                        cmd.drain = 1'b1;
                        cmd.out_sel = OSEL_DELAY;
                    end else begin
                        cmd.note = 1'b1;
                        cmd.parse = 1'b1;
                        cmd.out_sel = OSEL_NOTE;
                        state_next = S_END;
                    end
                end
            end
            S_END: begin
                if (!stat.is_last) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end else if (out_free) begin
                    cmd.finish = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_sel = OSEL_END;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/mtnw_dp.sv
`default_nettype none
module mtnw_dp
    import mtnw_pkg::*;
#(
    parameter int unsigned NOTE_COUNT = NOTE_COUNT_DEF,
    parameter int unsigned TIME_LIMIT = TIME_LIMIT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [TEMPO_W-1:0] cfg_tempo,
    input  wire logic [7:0]         in_byte,
    input  wire logic               in_last,
    input  wire cmd_t               cmd,
    input  wire logic               out_take,
    output status_t                 stat,
    output logic                    out_valid,
    output logic [15:0]             out_word,
    output logic [2:0]              out_kind,
    output logic                    out_last
);

    logic [7:0]          byte_reg;
    logic                last_reg;
    phase_t              phase_reg, phase_next;
    logic [3:0]          hdr_pos_reg, hdr_pos_next;
    logic [31:0]         hdr_size_reg, hdr_size_next;
    logic [8:0]          skip_reg, skip_next;
    logic [TEMPO_W-1:0]  tempo_reg, tempo_next;
    logic [TIME_W-1:0]   time_reg;
    logic [3:0]          dhi_reg, dhi_next;
    logic [7:0]          meta_reg, meta_next;
    logic                sent_reg;
    logic [10:0]         ticks_reg, ticks_next;
    logic                add_next;
    logic [34:0]         prod_reg;
    logic [39:0]         qprod;
    logic [TIME_W:0]     quot;
    logic [TIME_W+1:0]   sum;
    logic [16:0]         step;
    logic [16:0]         step_rom [128];
    logic                ovalid_reg;
    logic [15:0]         oword_reg;
    logic [2:0]          okind_reg;
    logic                olast_reg;
    logic                st_ph;

    for (genvar gi = 0; gi < 128; gi++) begin : g_step_rom
        assign step_rom[gi] = note_step(7'(gi));
    end

    always_comb begin
        phase_next = phase_reg;
        hdr_pos_next = hdr_pos_reg;
        hdr_size_next = hdr_size_reg;
        skip_next = skip_reg;
        tempo_next = tempo_reg;
        dhi_next = dhi_reg;
        meta_next = meta_reg;
        ticks_next = 11'd0;
        add_next = 1'b0;
        st_ph = 1'b0;
        unique case (phase_reg)
            PH_HEADER: begin
                if (hdr_pos_reg >= 4'd4) begin
                    hdr_size_next = {hdr_size_reg[23:0], byte_reg};
                end
                hdr_pos_next = hdr_pos_reg + 4'd1;
                if (hdr_pos_next >= 4'd8) begin
                    dhi_next = 4'd0;
                    if (hdr_size_next == 32'd0) begin
                        skip_next = 9'd8;
                        phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_HDRSKIP;
                    end
                end
            end
            PH_HDRSKIP: begin
                hdr_size_next = hdr_size_reg - 32'd1;
                if (hdr_size_next == 32'd0) begin
                    dhi_next = 4'd0;
                    skip_next = 9'd8;
                    phase_next = PH_SKIP;
                end
            end
            PH_DELTA: begin
                phase_next = PH_EVENT;
                if (byte_reg[7]) begin
                    dhi_next = byte_reg[3:0];
                    phase_next = PH_DELTA2;
                end else if (byte_reg != 8'd0) begin
                    ticks_next = {4'd0, byte_reg[6:0]};
                    add_next = 1'b1;
                end
            end
            PH_DELTA2: begin
                ticks_next = ({7'd0, dhi_reg} << 7) | {3'd0, byte_reg};
                add_next = 1'b1;
                dhi_next = 4'd0;
                phase_next = PH_EVENT;
            end
            PH_EVENT: begin
                if (byte_reg == 8'hFF) begin
                    phase_next = PH_METATYPE;
                end else if (byte_reg[7:4] == 4'hF) begin
                    phase_next = PH_SYSLEN;
                end else if (byte_reg[7:4] == 4'h9) begin
                    phase_next = PH_NOTE;
                end else if (byte_reg[7:4] == 4'hC || byte_reg[7:4] == 4'hD) begin
                    skip_next = 9'd1;
                    phase_next = PH_SKIP;
                end else begin
                    skip_next = 9'd2;
                    phase_next = PH_SKIP;
                end
            end
            PH_METATYPE: begin
                meta_next = byte_reg;
                phase_next = PH_METALEN;
            end
            PH_METALEN: begin
                dhi_next = (meta_reg == META_TEMPO && byte_reg >= 8'd3) ? 4'd3 : 4'd0;
                st_ph = 1'b1;
            end
            PH_SYSLEN: begin
                dhi_next = 4'd0;
                st_ph = 1'b1;
            end
            PH_NOTE: begin
                dhi_next = 4'd0;
                skip_next = 9'd1;
                phase_next = PH_SKIP;
            end
            PH_SKIP: begin
                if (dhi_reg != 4'd0) begin
                    tempo_next = {tempo_reg[TEMPO_W-9:0], byte_reg};
                    dhi_next = dhi_reg - 4'd1;
                end
                if (skip_reg != 9'd0) begin
                    skip_next = skip_reg - 9'd1;
                end
                if (skip_next == 9'd0) begin
                    dhi_next = 4'd0;
                    phase_next = PH_DELTA;
                end
            end
            default: phase_next = PH_HEADER;
        endcase
        if (st_ph) begin
            skip_next = {1'b0, byte_reg};
            phase_next = (byte_reg == 8'd0) ? PH_DELTA : PH_SKIP;
        end
    end

    // The quotient by 98304 = 3 * 2^15: a shift, then a reciprocal multiply for the 3.
    assign qprod = {20'd0, prod_reg[34:15]} * 40'd699051;
    assign quot = (TIME_W+1)'(qprod[39:21]);
    assign sum = {2'b0, time_reg} + {1'b0, quot};
    assign step = (byte_reg < NOTE_COUNT) ? step_rom[byte_reg[6:0]] : 17'h10000;

    assign stat.start_sent = sent_reg;
    assign stat.need_add = add_next;
    assign stat.is_note = (phase_reg == PH_NOTE);
    assign stat.time_zero = (time_reg == '0);
    assign stat.is_last = last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.parse) begin
            ticks_reg <= ticks_next;
        end
        if (cmd.mul) begin
            prod_reg <= 35'(ticks_reg) * 35'(tempo_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hdr_pos_reg <= 4'd0;
            hdr_size_reg <= 32'd0;
            skip_reg <= 9'd0;
            tempo_reg <= TEMPO_RESET;
            time_reg <= '0;
            dhi_reg <= 4'd0;
            meta_reg <= 8'd0;
            sent_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            oword_reg <= 16'd0;
            okind_reg <= KIND_START;
            olast_reg <= 1'b0;
        end else begin
            if (out_take) begin
                ovalid_reg <= 1'b0;
            end
            if (cmd.start_file) begin
                sent_reg <= 1'b1;
                tempo_reg <= cfg_tempo;
            end
            if (cmd.parse) begin
                phase_reg <= phase_next;
                hdr_pos_reg <= (hdr_pos_next > 4'd8) ? 4'd8 : hdr_pos_next;
                hdr_size_reg <= hdr_size_next;
                skip_reg <= skip_next;
                tempo_reg <= tempo_next;
                dhi_reg <= dhi_next;
                meta_reg <= meta_next;
            end
            if (cmd.acc) begin
                time_reg <= (sum > (TIME_W+2)'(TIME_LIMIT)) ? TIME_W'(TIME_LIMIT)
                                                          : sum[TIME_W-1:0];
            end
            if (cmd.drain) begin
                time_reg <= (time_reg >= 21'h8000) ? time_reg - DELAY_MAX : '0;
            end
            if (cmd.out_load) begin
                ovalid_reg <= 1'b1;
                unique case (cmd.out_sel)
                    OSEL_START: begin
                        oword_reg <= WORD_START;
                        okind_reg <= KIND_START;
                        olast_reg <= !last_reg;
                    end
                    OSEL_DELAY: begin
                        oword_reg <= (time_reg >= 21'h8000) ? WORD_END
                                     : WORD_DELAY | time_reg[15:0];
                        okind_reg <= KIND_DELAY;
                        olast_reg <= 1'b0;
                    end
                    OSEL_NOTE: begin
                        oword_reg <= step[16] ? 16'd0 : step[15:0];
                        okind_reg <= step[16] ? KIND_RANGE : KIND_NOTE;
                        olast_reg <= !last_reg;
                    end
                    default: begin
                        oword_reg <= WORD_END;
                        okind_reg <= KIND_END;
                        olast_reg <= 1'b1;
                    end
                endcase
            end
            if (cmd.finish && last_reg) begin
                phase_reg <= PH_HEADER;
                hdr_pos_reg <= 4'd0;
                hdr_size_reg <= 32'd0;
                skip_reg <= 9'd0;
                tempo_reg <= cfg_tempo;
                time_reg <= '0;
                dhi_reg <= 4'd0;
                meta_reg <= 8'd0;
                sent_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_word = oword_reg;
    assign out_kind = okind_reg;
    assign out_last = olast_reg;

endmodule
`default_nettype wire

>>> rtl/core/midi_track_to_note_words_top.sv
// Channel | Dir | tdata                  | tuser            | tlast
// s_      | in  | [7:0] data byte        | none             | last byte of file
// m_      | out | [15:0] word            | [2:0] word kind  | final result of byte
// An ordinary byte goes from its request to the next ready through accept, start
// check, parse and finish. A delta byte that adds time also passes through the
// tempo multiply and the divide by 98304. A note-on stays in the drain state while
// its delay words go out, then sends the note word. Start and end words go out in
// the start check and finish steps; a stalled output holds the controller.
// Reset is synchronous on aresetn low.
`default_nettype none
module midi_track_to_note_words_top
    import mtnw_pkg::*;
#(
    parameter int unsigned NOTE_COUNT = NOTE_COUNT_DEF,
    parameter int unsigned TIME_LIMIT = TIME_LIMIT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [TEMPO_W-1:0] cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] data_byte
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,   // [15:0] word
    output logic [2:0]              m_tuser,   // [2:0] word_kind
    output logic                    m_tlast
);

    logic [TEMPO_W-1:0] tempo_cfg_reg;
    cmd_t               cmd;
    status_t            stat;
    logic               ovalid;
    logic               take;
    logic               free;
    logic               last_pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tempo_cfg_reg <= TEMPO_RESET;
        end else if (cfg_we) begin
            tempo_cfg_reg <= cfg_wdata;
        end
    end

    assign take = m_tvalid && m_tready;
    assign free = !ovalid || m_tready;

    mtnw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (s_tvalid && s_tready),
        .out_free (free),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    mtnw_dp #(
        .NOTE_COUNT (NOTE_COUNT),
        .TIME_LIMIT (TIME_LIMIT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_tempo (tempo_cfg_reg),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .out_take  (take),
        .stat      (stat),
        .out_valid (ovalid),
        .out_word  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (last_pend_reg)
    );

    assign m_tvalid = ovalid;
    assign m_tlast = last_pend_reg;

endmodule
`default_nettype wire

>>> rtl/core/mtnw_checker.sv
`default_nettype none
`include "midi_track_to_note_words_top_macros.svh"
module mtnw_checker
    import mtnw_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    `MTN_ASSERT_SAME(a_end_last, aclk, aresetn, m_tvalid && m_tuser == KIND_END, m_tlast, "end word must close the run")
    `MTN_ASSERT_SAME(a_start_word, aclk, aresetn, m_tvalid && m_tuser == KIND_START, m_tdata == WORD_START, "bad start word")
    `MTN_ASSERT_SAME(a_range_zero, aclk, aresetn, m_tvalid && m_tuser == KIND_RANGE, m_tdata == 16'h0000, "out of range note must carry zero")
    `MTN_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `MTN_ASSERT_NEXT(a_one_req, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input ready right after a request")

endmodule

bind midi_track_to_note_words_top mtnw_checker u_mtnw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

>>> sim/tb_midi_track_to_note_words_top.sv
`default_nettype none
module tb_midi_track_to_note_words_top;
    import mtnw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT = 5000;
    localparam int unsigned TARGET_BYTES = 400;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [7:0] META_EVENT = 8'hFF;
    localparam logic [7:0] META_TEXT = 8'h01;
    localparam logic [7:0] NOTE_ON = 8'h90;

    typedef struct {
        logic [15:0] word;
        kind_t       kind;
        logic        last;
    } note_word_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        chk;
        logic [15:0] word;
        logic [2:0]  kind;
    } midi_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [TEMPO_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;
    logic [2:0]         m_tuser;
    logic               m_tlast;

    midi_track_to_note_words_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    note_word_t  pending_words[$];
    note_word_t  first_word;
    logic [7:0]  file_bytes[$];
    int unsigned errors = 0;
    int unsigned bytes_sent = 0;
    int unsigned idle_cycles = 0;
    bit          quiet = 0;
    bit          hold_req = 0;

    // Parser state mirrored from the block.
    logic [TEMPO_W-1:0] tempo_reg;
    phase_t             phase;
    int unsigned        position;
    logic [31:0]        hdr_size;
    logic [8:0]         skip_left;
    logic [TEMPO_W-1:0] tempo;
    logic [31:0]        time_store;
    logic [3:0]         high_bits;
    logic [7:0]         meta_type;
    bit                 started;

    localparam longint unsigned SEMITONE[12] = '{
        64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
        64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
        64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
    };

    localparam midi_row_t DIRECTED[32] = '{
        '{8'h4D, 1'b0, 1'b1, WORD_START, KIND_START},
        '{8'h54, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'h68, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h64, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'h00, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h00, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'h00, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h00, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'h4D, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h54, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'h72, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h6B, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'h00, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h00, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'h00, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h20, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h7F, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'hFF, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'h51, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h03, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'hFF, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'hFF, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'hFF, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h8F, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'hFF, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h9F, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h7F, 1'b0, 1'b1, WORD_END, KIND_DELAY},
        '{8'h00, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'h00, 1'b0, 1'b0, 16'h0, 3'd0}, '{8'h90, 1'b0, 1'b0, 16'h0, 3'd0},
        '{8'hFF, 1'b0, 1'b1, 16'h0000, KIND_RANGE},
        '{8'h00, 1'b1, 1'b1, WORD_END, KIND_END}
    };

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void clear_file();
        phase = PH_HEADER;
        position = 0;
        hdr_size = 0;
        skip_left = 0;
        tempo = tempo_reg;
        time_store = 0;
        high_bits = 0;
        meta_type = 0;
        started = 0;
    endfunction

    function automatic void begin_skip(input logic [31:0] count);
        skip_left = count[8:0];
        phase = (skip_left == 0) ? PH_DELTA : PH_SKIP;
    endfunction

    function automatic void add_ticks(input logic [31:0] ticks);
        longint unsigned sum;
        sum = longint'(time_store) + (longint'(ticks) * longint'(tempo)) / 98304;
        time_store = (sum > TIME_LIMIT_DEF) ? TIME_LIMIT_DEF : sum[31:0];
    endfunction

    // Works out the words caused by one file byte and queues them.
    function automatic int predict_words(input logic [7:0] b, input logic is_last);
        note_word_t      res[$];
        note_word_t      w;
        longint unsigned step;
        if (!started) begin
            started = 1;
            tempo = tempo_reg;
            w = '{WORD_START, KIND_START, 1'b0};
            res.push_back(w);
        end
        case (phase)
            PH_HEADER: begin
                if (position >= 4) hdr_size = {hdr_size[23:0], b};
                position++;
                if (position >= 8) begin
                    high_bits = 0;
                    if (hdr_size == 0) begin_skip(8);
                    else phase = PH_HDRSKIP;
                end
            end
            PH_HDRSKIP: begin
                hdr_size--;
                if (hdr_size == 0) begin
                    high_bits = 0;
                    begin_skip(8);
                end
            end
            PH_DELTA: begin
                if (b == 0) begin
                    phase = PH_EVENT;
                end else if (b < 8'h80) begin
                    add_ticks(b);
                    phase = PH_EVENT;
                end else begin
                    high_bits = b[3:0];
                    phase = PH_DELTA2;
                end
            end
            PH_DELTA2: begin
                add_ticks({high_bits, b[6:0]} | {b[7], 7'b0});
                high_bits = 0;
                phase = PH_EVENT;
            end
            PH_EVENT: begin
                if (b == META_EVENT) phase = PH_METATYPE;
                else if (b[7:4] == 4'hF) phase = PH_SYSLEN;
                else if (b[7:4] == 4'h9) phase = PH_NOTE;
                else if (b[7:4] == 4'hC || b[7:4] == 4'hD) begin_skip(1);
                else begin_skip(2);
            end
            PH_METATYPE: begin
                meta_type = b;
                phase = PH_METALEN;
            end
            PH_METALEN: begin
                high_bits = (meta_type == META_TEMPO && b >= 3) ? 4'd3 : 4'd0;
                begin_skip(b);
            end
            PH_SYSLEN: begin
                high_bits = 0;
                begin_skip(b);
            end
            PH_NOTE: begin
                while (time_store != 0) begin
                    if (time_store >= 32'h8000) begin
                        w = '{16'hFFFF, KIND_DELAY, 1'b0};
                        time_store -= 32'h7FFF;
                    end else begin
                        w = '{WORD_DELAY + time_store[15:0], KIND_DELAY, 1'b0};
                        time_store = 0;
                    end
                    res.push_back(w);
                end
                step = 32'h8000;
                if (b < NOTE_COUNT_DEF)
                    step = ((64'd225792 * SEMITONE[b % 12]) << (b / 12)) / 64'd10000000000000;
                if (step < 32'h8000) w = '{step[15:0], KIND_NOTE, 1'b0};
                else w = '{16'h0000, KIND_RANGE, 1'b0};
                res.push_back(w);
                high_bits = 0;
                begin_skip(1);
            end
            default: begin
                if (high_bits != 0) begin
                    tempo = {tempo[15:0], b};
                    high_bits--;
                end
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) begin
                    high_bits = 0;
                    phase = PH_DELTA;
                end
            end
        endcase
        if (is_last) begin
            w = '{WORD_END, KIND_END, 1'b0};
            res.push_back(w);
            clear_file();
        end
        if (res.size() > 0) begin
            res[res.size() - 1].last = 1'b1;
            first_word = res[0];
        end
        foreach (res[i]) pending_words.push_back(res[i]);
        return res.size();
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last, output int count);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= is_last;
        do @(posedge aclk); while (!s_tready);
        count = predict_words(b, is_last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic write_tempo(input logic [TEMPO_W-1:0] value);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        tempo_reg = value;
        if (!started) tempo = value;
    endtask

    task automatic push_delta();
        logic [7:0] hi;
        case ($urandom_range(0, 3))
            0: file_bytes.push_back(8'h00);
            1: file_bytes.push_back(8'($urandom_range(1, 127)));
            default: begin
                hi = 8'($urandom_range(128, 255));
                file_bytes.push_back(hi);
                file_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Builds one file: a well-formed track most of the time, otherwise raw noise.
    task automatic build_file();
        int unsigned hsz;
        int unsigned n;
        logic [7:0]  st;
        file_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom));
            return;
        end
        hsz = $urandom_range(0, 6);
        repeat (4) file_bytes.push_back(8'($urandom));
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'(hsz));
        repeat (hsz + 8) file_bytes.push_back(8'($urandom));
        repeat ($urandom_range(2, 10)) begin
            push_delta();
            case ($urandom_range(0, 9))
                0, 1: begin
                    file_bytes.push_back(META_EVENT);
                    file_bytes.push_back(META_TEMPO);
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 5);
                    file_bytes.push_back(8'(n));
                    repeat (n) file_bytes.push_back(8'($urandom));
                end
                2: begin
                    file_bytes.push_back(META_EVENT);
                    file_bytes.push_back(($urandom_range(0, 1) == 0) ? META_TEXT
                                                                     : 8'($urandom));
                    n = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 255)
                                                     : $urandom_range(0, 4);
                    file_bytes.push_back(8'(n));
                    repeat (n) file_bytes.push_back(8'($urandom));
                end
                3: begin
                    file_bytes.push_back(8'($urandom_range(240, 254)));
                    n = $urandom_range(0, 3);
                    file_bytes.push_back(8'(n));
                    repeat (n) file_bytes.push_back(8'($urandom));
                end
                4: begin
                    st = 8'($urandom);
                    file_bytes.push_back(st);
                    if (st[7:4] == 4'hC || st[7:4] == 4'hD) begin
                        file_bytes.push_back(8'($urandom));
                    end else if (st != META_EVENT && st[7:4] != 4'hF && st[7:4] != 4'h9) begin
                        file_bytes.push_back(8'($urandom));
                        file_bytes.push_back(8'($urandom));
                    end else begin
                        file_bytes.push_back(8'h00);
                        file_bytes.push_back(8'h00);
                    end
                end
                default: begin
                    file_bytes.push_back(NOTE_ON | 8'($urandom_range(0, 15)));
                    file_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                    : 8'($urandom_range(0, 127)));
                    file_bytes.push_back(8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        int         count;
        int unsigned files;
        logic [TEMPO_W-1:0] settings[4];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        tempo_reg = TEMPO_RESET;
        clear_file();
        settings = '{24'd0, 24'hFFFFFF, TEMPO_RESET, 24'd62500};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (DIRECTED[i]) begin
            send_byte(DIRECTED[i].data, DIRECTED[i].last, count);
            if (DIRECTED[i].chk && (count == 0 || first_word.word != DIRECTED[i].word
                    || first_word.kind != kind_t'(DIRECTED[i].kind))) begin
                $display("%0t: byte %0d expected word %h kind %0d, got word %h kind %0d",
                         $time, i, DIRECTED[i].word, DIRECTED[i].kind,
                         first_word.word, first_word.kind);
                errors++;
            end
        end
        hold_req = 1;
        files = 0;
        while (bytes_sent < TARGET_BYTES) begin
            if (files % 4 == 0)
                write_tempo((files / 4 < 4) ? settings[files / 4] : 24'($urandom));
            if (bytes_sent > TARGET_BYTES - 80) quiet = 1;
            build_file();
            foreach (file_bytes[j])
                send_byte(file_bytes[j], j == file_bytes.size() - 1, count);
            files++;
        end
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        note_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h kind %0d last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                exp_w = pending_words.pop_front();
                if (m_tdata != exp_w.word || m_tuser != exp_w.kind || m_tlast != exp_w.last) begin
                    $display("%0t: expected word %h kind %0d last %b, got %h kind %0d last %b",
                             $time, exp_w.word, exp_w.kind, exp_w.last,
                             m_tdata, m_tuser, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
`default_nettype wire
